// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// No dependencies; used by sorted_priority_queue.
package spq_pkg;

	// command codes on the cmd port
	localparam logic [2:0] CMD_ENQ   = 3'd0;
	localparam logic [2:0] CMD_DEQ   = 3'd1;
	localparam logic [2:0] CMD_RMAT  = 3'd2;
	localparam logic [2:0] CMD_RMTAG = 3'd3;
	localparam logic [2:0] CMD_RDAT  = 3'd4;

	// config register indexes
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_TIE   = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ_RD,
		S_ENQ_CMP,
		S_ENQ_WR,
		S_FIND_RD,
		S_FIND_CHK,
		S_SH_RD,
		S_SH_WR
	} state_t;

endpackage

// ----- sv/spq_store.sv -----
// Entry store for the sorted priority queue: one write port, one read port,
// registered read data. No dependencies.
module spq_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue: sequencer, key/tag compare unit and config registers.
// Depends on spq_pkg and spq_store.
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------------
//  command   | cmd, key, tag, index                           | taken when start && !busy
//  result    | status, out_valid, out_key, out_tag, count,    | one-cycle strobe on done
//            | empty_res                                      |
//  config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB write, pready always 1
//
// Work per command:
//   enqueue: shift back the entries the new key beats; remove: move later entries up;
//   search by tag: scan entries until the tag matches, then move later entries up;
//   read at index: read the one entry; any rejected command: reported without touching the store.
// Every entry moves through the single memory read port and one compare unit.
// Reset clears the fill count and config; the store needs no clearing pass.
// busy is high from the cycle after acceptance until done pulses; a rejected command
// never raises it. Results cannot be stalled.
module sorted_priority_queue #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32,
	parameter int TAG_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           cmd,
	input  logic [KEY_WIDTH-1:0] key,
	input  logic [TAG_WIDTH-1:0] tag,
	input  logic [3:0]           index,
	// result
	output logic                 done,
	output logic [1:0]           status,
	output logic                 out_valid,
	output logic [KEY_WIDTH-1:0] out_key,
	output logic [TAG_WIDTH-1:0] out_tag,
	output logic [4:0]           count,
	output logic                 empty_res,
	// config
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 4) ? CW : 4;
	localparam int EW = KEY_WIDTH + TAG_WIDTH;

	spq_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    pos_q, pos_d, pos_m1, pos_p1;
	logic [2:0]       cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic             order_q, tie_q;

	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [EW-1:0]    wr_data, rd_data;
	logic [KEY_WIDTH-1:0] rd_key;
	logic [TAG_WIDTH-1:0] rd_tag;

	logic             fin, fin_valid, fill_inc, fill_dec, hit_cap;
	spq_pkg::status_t fin_status;
	logic             beats, tag_hit, cfg_wr, accept;
	logic             status_bad;

	spq_pkg::status_t status_q;
	logic             valid_q, done_q;
	logic [KEY_WIDTH-1:0] okey_q;
	logic [TAG_WIDTH-1:0] otag_q;

	spq_store #(
		.DEPTH(DEPTH),
		.WIDTH(EW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_key = rd_data[EW-1:TAG_WIDTH];
	assign rd_tag = rd_data[TAG_WIDTH-1:0];
	assign pos_m1 = pos_q - 1'b1;
	assign pos_p1 = pos_q + 1'b1;

	// shared compare unit: does the new key go ahead of the stored one
	always_comb begin
		if (key_q == rd_key) begin
			beats = tie_q;
		end else if (order_q) begin
			beats = key_q > rd_key;
		end else begin
			beats = key_q < rd_key;
		end
	end
	assign tag_hit = (cmd_q != spq_pkg::CMD_RMTAG) || (rd_tag == tag_q);

	assign busy   = state_q != spq_pkg::S_IDLE;
	assign accept = start && !busy;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {31'b0, (paddr[2] == spq_pkg::REG_TIE) ? tie_q : order_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			tie_q   <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == spq_pkg::REG_ORDER) begin
				order_q <= pwdata[0];
			end else begin
				tie_q <= pwdata[0];
			end
		end
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		rd_en      = 1'b0;
		rd_addr    = pos_q[AW-1:0];
		wr_en      = 1'b0;
		wr_addr    = pos_q[AW-1:0];
		wr_data    = {key_q, tag_q};
		fin        = 1'b0;
		fin_valid  = 1'b0;
		fin_status = spq_pkg::STAT_OK;
		fill_inc   = 1'b0;
		fill_dec   = 1'b0;
		hit_cap    = 1'b0;
		case (state_q)
			spq_pkg::S_IDLE: begin
				if (start) begin
					case (cmd)
						spq_pkg::CMD_ENQ: begin
							if (fill_q == CW'(DEPTH)) begin
								fin        = 1'b1;
								fin_status = spq_pkg::STAT_FULL;
							end else begin
								pos_d   = fill_q;
								state_d = (fill_q == '0) ? spq_pkg::S_ENQ_WR
								                         : spq_pkg::S_ENQ_RD;
							end
						end
						spq_pkg::CMD_DEQ, spq_pkg::CMD_RMAT, spq_pkg::CMD_RDAT: begin
							if (fill_q == '0 ||
							    (cmd != spq_pkg::CMD_DEQ && PW'(index) >= PW'(fill_q))) begin
								fin        = 1'b1;
								fin_status = spq_pkg::STAT_EMPTY;
							end else begin
								pos_d   = (cmd == spq_pkg::CMD_DEQ) ? '0 : CW'(index);
								state_d = spq_pkg::S_FIND_RD;
							end
						end
						spq_pkg::CMD_RMTAG: begin
							if (fill_q == '0) begin
								fin        = 1'b1;
								fin_status = spq_pkg::STAT_EMPTY;
							end else begin
								pos_d   = '0;
								state_d = spq_pkg::S_FIND_RD;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			spq_pkg::S_ENQ_RD: begin
				rd_en   = 1'b1;
				rd_addr = pos_m1[AW-1:0];
				state_d = spq_pkg::S_ENQ_CMP;
			end
			spq_pkg::S_ENQ_CMP: begin
				if (beats) begin
					// move the entry one place back and keep walking toward the head
					wr_en   = 1'b1;
					wr_data = rd_data;
					pos_d   = pos_m1;
					state_d = (pos_m1 == '0) ? spq_pkg::S_ENQ_WR : spq_pkg::S_ENQ_RD;
				end else begin
					state_d = spq_pkg::S_ENQ_WR;
				end
			end
			spq_pkg::S_ENQ_WR: begin
				wr_en    = 1'b1;
				fin      = 1'b1;
				fill_inc = 1'b1;
				state_d  = spq_pkg::S_IDLE;
			end
			spq_pkg::S_FIND_RD: begin
				rd_en   = 1'b1;
				state_d = spq_pkg::S_FIND_CHK;
			end
			spq_pkg::S_FIND_CHK: begin
				if (!tag_hit) begin
					if (pos_p1 == fill_q) begin
						fin        = 1'b1;
						fin_status = spq_pkg::STAT_NOTFOUND;
						state_d    = spq_pkg::S_IDLE;
					end else begin
						pos_d   = pos_p1;
						state_d = spq_pkg::S_FIND_RD;
					end
				end else begin
					hit_cap = 1'b1;
					if (cmd_q == spq_pkg::CMD_RDAT) begin
						fin       = 1'b1;
						fin_valid = 1'b1;
						state_d   = spq_pkg::S_IDLE;
					end else if (pos_p1 == fill_q) begin
						fin       = 1'b1;
						fin_valid = 1'b1;
						fill_dec  = 1'b1;
						state_d   = spq_pkg::S_IDLE;
					end else begin
						pos_d   = pos_p1;
						state_d = spq_pkg::S_SH_RD;
					end
				end
			end
			spq_pkg::S_SH_RD: begin
				rd_en   = 1'b1;
				state_d = spq_pkg::S_SH_WR;
			end
			spq_pkg::S_SH_WR: begin
				// close the gap: entry at pos moves up to pos-1
				wr_en   = 1'b1;
				wr_addr = pos_m1[AW-1:0];
				wr_data = rd_data;
				pos_d   = pos_p1;
				if (pos_p1 == fill_q) begin
					fin       = 1'b1;
					fin_valid = 1'b1;
					fill_dec  = 1'b1;
					state_d   = spq_pkg::S_IDLE;
				end else begin
					state_d = spq_pkg::S_SH_RD;
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end else if (fill_dec) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (accept) begin
			cmd_q <= cmd;
			key_q <= key;
			tag_q <= tag;
		end
		if (fin) begin
			status_q <= fin_status;
			valid_q  <= fin_valid;
		end
		if (hit_cap) begin
			okey_q <= rd_key;
			otag_q <= rd_tag;
		end else if (fin && !fin_valid) begin
			okey_q <= '0;
			otag_q <= '0;
		end
	end

	// status word sanity flag for the checks below
	assign status_bad = valid_q && (status_q != spq_pkg::STAT_OK);

	assign done      = done_q;
	assign status    = status_q;
	assign out_valid = valid_q;
	assign out_key   = okey_q;
	assign out_tag   = otag_q;
	assign count     = 5'(fill_q);
	assign empty_res = fill_q == '0;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == spq_pkg::S_IDLE)
		else $error("result strobe while sequencer busy");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == spq_pkg::CMD_ENQ && fill_q == CW'(DEPTH))
		|=> done_q && status_q == spq_pkg::STAT_FULL && fill_q == CW'(DEPTH))
		else $error("enqueue on full store not rejected");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q != spq_pkg::S_IDLE)
		else $error("store written while idle");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !status_bad)
		else $error("valid word with failure status");

endmodule

// ----- bench/tb_sorted_priority_queue.sv -----
// Self-checking bench for sorted_priority_queue: directed and random command words
// checked against an in-bench predictor of the queue contents.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

	localparam int KEY_W      = 32;
	localparam int TAG_W      = 16;
	localparam int QUIET_MAX  = 2000;   // cycles with no word moving before giving up
	localparam int TAIL_WAIT  = 40;     // covers the longest command
	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 155;

	typedef struct {
		spq_pkg::status_t status;
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [4:0]       count;
		logic             empty;
	} result_word_t;

	class priority_tracker;
		localparam int SLOTS = 16;
		logic [KEY_W-1:0] keys[SLOTS];
		logic [TAG_W-1:0] tags[SLOTS];
		int               fill = 0;
		bit               larger_first = 1'b0;
		bit               tie_first = 1'b0;
		result_word_t     expected_words[$];
		int               mismatches = 0;

		// new key lands ahead of an existing one?
		function bit goes_ahead(logic [KEY_W-1:0] nk, logic [KEY_W-1:0] ok);
			if (nk == ok)
				return tie_first;
			if (larger_first)
				return nk > ok;
			return nk < ok;
		endfunction

		function void drop(int p);
			for (int i = p + 1; i < fill; i++) begin
				keys[i-1] = keys[i];
				tags[i-1] = tags[i];
			end
			fill--;
		endfunction

		function void apply_command(logic [2:0] c, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
				logic [3:0] ix);
			result_word_t w;
			int p;
			w.status = spq_pkg::STAT_OK;
			w.valid  = 1'b0;
			w.key    = '0;
			w.tag    = '0;
			case (c)
				spq_pkg::CMD_ENQ: begin
					if (fill >= SLOTS) begin
						w.status = spq_pkg::STAT_FULL;
					end else begin
						p = fill;
						while (p != 0 && goes_ahead(k, keys[p-1])) begin
							keys[p] = keys[p-1];
							tags[p] = tags[p-1];
							p--;
						end
						keys[p] = k;
						tags[p] = t;
						fill++;
					end
				end
				spq_pkg::CMD_DEQ, spq_pkg::CMD_RMAT, spq_pkg::CMD_RDAT: begin
					p = (c == spq_pkg::CMD_DEQ) ? 0 : int'(ix);
					if (p >= fill) begin
						w.status = spq_pkg::STAT_EMPTY;
					end else begin
						w.valid = 1'b1;
						w.key   = keys[p];
						w.tag   = tags[p];
						if (c != spq_pkg::CMD_RDAT)
							drop(p);
					end
				end
				spq_pkg::CMD_RMTAG: begin
					if (fill == 0) begin
						w.status = spq_pkg::STAT_EMPTY;
					end else begin
						w.status = spq_pkg::STAT_NOTFOUND;
						for (int i = 0; i < fill; i++) begin
							if (tags[i] == t) begin
								w.status = spq_pkg::STAT_OK;
								w.valid  = 1'b1;
								w.key    = keys[i];
								w.tag    = tags[i];
								drop(i);
								break;
							end
						end
					end
				end
				default: ;  // spare codes do nothing
			endcase
			w.count = 5'(fill);
			w.empty = (fill == 0);
			expected_words.push_back(w);
		endfunction

		task log_mismatch(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_word(logic [1:0] st, logic v, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
				logic [4:0] n, logic e);
			result_word_t w;
			if (expected_words.size() == 0) begin
				log_mismatch($sformatf("result word with nothing pending, status %0d", st));
				return;
			end
			w = expected_words.pop_front();
			if (st !== w.status)
				log_mismatch($sformatf("status %0d, want %0d", st, w.status));
			if (v !== w.valid)
				log_mismatch($sformatf("out_valid %0b, want %0b", v, w.valid));
			if (k !== w.key)
				log_mismatch($sformatf("out_key %h, want %h", k, w.key));
			if (t !== w.tag)
				log_mismatch($sformatf("out_tag %h, want %h", t, w.tag));
			if (n !== w.count)
				log_mismatch($sformatf("count %0d, want %0d", n, w.count));
			if (e !== w.empty)
				log_mismatch($sformatf("empty_res %0b, want %0b", e, w.empty));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [2:0]       cmd = spq_pkg::CMD_ENQ;
	logic [KEY_W-1:0] key = '0;
	logic [TAG_W-1:0] tag = '0;
	logic [3:0]       index = '0;
	logic             done;
	logic [1:0]       status;
	logic             out_valid;
	logic [KEY_W-1:0] out_key;
	logic [TAG_W-1:0] out_tag;
	logic [4:0]       count;
	logic             empty_res;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;

	priority_tracker tracker = new();
	int quiet = 0;

	sorted_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.key(key),
		.tag(tag),
		.index(index),
		.done(done),
		.status(status),
		.out_valid(out_valid),
		.out_key(out_key),
		.out_tag(out_tag),
		.count(count),
		.empty_res(empty_res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (done)
			tracker.check_word(status, out_valid, out_key, out_tag, count, empty_res);
		if (done || (start && !busy))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one command word and hold it until taken. start is only lowered here,
	// so a word is never taken twice.
	task automatic issue(logic [2:0] c, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
			logic [3:0] ix, int gap_after, bit last);
		start <= 1'b1;
		cmd   <= c;
		key   <= k;
		tag   <= t;
		index <= ix;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.apply_command(c, k, t, ix);
		if (last || gap_after != 0) begin
			start <= 1'b0;
			repeat (gap_after) @(posedge clk);
		end
	endtask

	task automatic settle();
		while (tracker.expected_words.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic ridx, bit val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {ridx, 2'b00};
		pwdata  <= {31'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (ridx == spq_pkg::REG_ORDER)
			tracker.larger_first = val;
		else
			tracker.tie_first = val;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return KEY_W'($urandom_range(0, 7));      // dense values, lots of ties
			3: return 32'hFFFF_FFF8 | KEY_W'($urandom_range(0, 7));
			4: return 32'h7FFF_FFFC + KEY_W'($urandom_range(0, 7));
			default: return KEY_W'($urandom);
		endcase
	endfunction

	task automatic make_random(int enq_pct, output logic [2:0] c, output logic [KEY_W-1:0] k,
			output logic [TAG_W-1:0] t, output logic [3:0] ix);
		int r;
		r = $urandom_range(0, 99);
		if (r < enq_pct)
			c = spq_pkg::CMD_ENQ;
		else if (r >= 97)
			c = spq_pkg::CMD_RDAT + 3'($urandom_range(1, 3));  // spare codes
		else begin
			case ($urandom_range(0, 3))
				0: c = spq_pkg::CMD_DEQ;
				1: c = spq_pkg::CMD_RMAT;
				2: c = spq_pkg::CMD_RMTAG;
				default: c = spq_pkg::CMD_RDAT;
			endcase
		end
		k = pick_key();
		t = $urandom_range(0, 1) ? TAG_W'($urandom_range(0, 7)) : TAG_W'($urandom);
		// mostly aim tag removal at a live entry; small tag range gives duplicates
		if (c == spq_pkg::CMD_RMTAG && tracker.fill != 0 && $urandom_range(0, 9) < 7)
			t = tracker.tags[$urandom_range(0, tracker.fill - 1)];
		if (tracker.fill != 0 && $urandom_range(0, 3) != 0)
			ix = 4'($urandom_range(0, tracker.fill - 1));
		else
			ix = 4'($urandom_range(0, 15));
	endtask

	initial begin
		logic [2:0]       c;
		logic [KEY_W-1:0] k;
		logic [TAG_W-1:0] t;
		logic [3:0]       ix;
		int               enq_pct;
		int               gap;
		bit               last;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, spare codes, key/tag extremes, ties, bad indexes
		issue(spq_pkg::CMD_DEQ, '0, '0, 4'd0, 0, 0);
		issue(spq_pkg::CMD_RMTAG, '0, 16'h1234, 4'd0, 1, 0);
		issue(spq_pkg::CMD_RDAT, '0, '0, 4'd0, 0, 0);
		issue(spq_pkg::CMD_RMAT, '0, '0, 4'd0, 2, 0);
		for (int i = 1; i <= 3; i++)
			issue(spq_pkg::CMD_RDAT + 3'(i), '1, '1, 4'hF, 0, 0);
		issue(spq_pkg::CMD_ENQ, '0, '0, 4'd0, 0, 0);
		issue(spq_pkg::CMD_ENQ, '1, '1, 4'd0, 3, 0);
		issue(spq_pkg::CMD_ENQ, '0, 16'h0001, 4'd0, 0, 0);
		issue(spq_pkg::CMD_ENQ, 32'h8000_0000, 16'h8000, 4'd0, 0, 0);
		for (int i = 0; i < 4; i++)
			issue(spq_pkg::CMD_RDAT, '0, '0, 4'(i), 0, 0);
		issue(spq_pkg::CMD_RDAT, '0, '0, 4'hF, 1, 0);
		issue(spq_pkg::CMD_RMAT, '0, '0, 4'hF, 0, 0);
		issue(spq_pkg::CMD_RMTAG, '0, 16'h5555, 4'd0, 0, 0);
		issue(spq_pkg::CMD_RMTAG, '0, 16'hFFFF, 4'd0, 0, 0);
		issue(spq_pkg::CMD_RMAT, '0, '0, 4'd1, 0, 0);
		issue(spq_pkg::CMD_DEQ, '0, '0, 4'd0, 0, 0);
		issue(spq_pkg::CMD_DEQ, '0, '0, 4'd0, 0, 0);
		issue(spq_pkg::CMD_DEQ, '0, '0, 4'd0, 0, 1);

		// random phases: each sets one order/tie setting and a fill bias; together they walk every setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(spq_pkg::REG_ORDER, ph[0]);
			write_reg(spq_pkg::REG_TIE, ph[1]);
			case (ph % 3)
				0: enq_pct = 75;   // runs up to full
				1: enq_pct = 50;
				default: enq_pct = 35;   // drains to empty
			endcase
			for (int n = 0; n < PHASE_LEN; n++) begin
				gap  = (n % 40 < 10) ? 0 : $urandom_range(0, 3);
				last = (n == PHASE_LEN - 1) || (ph == 4 && n == PHASE_LEN / 2);
				make_random(enq_pct, c, k, t, ix);
				issue(c, k, t, ix, gap, last);
				if (ph == 4 && n == PHASE_LEN / 2)
					settle();   // let the queue go fully quiet mid-phase
			end
		end

		while (tracker.expected_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
